/* hw/rtl/kmp_pkg.sv */
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and constants for the KMP pattern matcher
// Opcodes, the pattern row size and the control group that drives the cells.
// ----------------------------------------------------------------------------
package kmp_pkg;

    // Pattern sizing: the pattern store holds at most STORE_DEPTH - 1 bytes
    localparam int MAX_PATTERN = 255;
    localparam int STORE_DEPTH = 256;
    localparam int PAT_LIMIT   = (MAX_PATTERN < STORE_DEPTH - 1) ? MAX_PATTERN
                                                                 : STORE_DEPTH - 1;
    localparam int LEN_W       = $clog2(PAT_LIMIT + 1);

    // Counter widths and saturation value
    localparam int          CNT_W   = 32;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_FINISH = 2'd1,
        OP_TEXT   = 2'd2,
        OP_BREAK  = 2'd3
    } op_t;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic       load;     // shift a pattern byte into the row
        logic       restart;  // new pattern: drop all stored bytes above the head
        logic       step;     // text byte: advance the partial-match bits
        logic       clear;    // drop match progress
        logic [7:0] data;     // pattern byte or text byte
    } cell_ctrl_t;

endpackage

/* hw/rtl/kmp_cell.sv */
// ----------------------------------------------------------------------------
// kmp_cell: one position of the pattern row
// Holds one pattern byte and one partial-match bit. Pattern bytes shift
// upward through the row; partial-match bits move downward toward cell 0.
// ----------------------------------------------------------------------------
module kmp_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  kmp_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          byte_in,    // from lower neighbor (or new byte)
    input  logic                valid_in,   // from lower neighbor (or head)
    input  logic                prog_in,    // from upper neighbor
    output logic [7:0]          byte_out,
    output logic                valid_out,
    output logic                prog_out,
    output logic                hit
);

    logic [7:0] pat_byte_reg;
    logic       valid_reg;
    logic       valid_next;
    logic       prog_reg;
    logic       prog_next;
    logic       byte_eq;

    // Suffix of the text matches this cell and every cell above it
    assign byte_eq = (ctrl.data == pat_byte_reg);
    assign hit     = valid_reg & prog_in & byte_eq;

    // Cells past the pattern end act as an always-true boundary
    assign byte_out  = pat_byte_reg;
    assign valid_out = valid_reg;
    assign prog_out  = valid_reg ? prog_reg : 1'b1;

    always_comb
    begin
        valid_next = valid_reg;
        prog_next  = prog_reg;
        if (ctrl.load)
        begin
            valid_next = valid_in;
        end
        if (ctrl.clear)
        begin
            prog_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            prog_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            prog_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            prog_reg  <= prog_next;
        end
    end

    // Pattern byte storage
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pat_byte_reg <= byte_in;
        end
    end

endmodule

/* hw/rtl/kmp_pattern_matcher.sv */
// ----------------------------------------------------------------------------
// kmp_pattern_matcher: streaming exact-pattern matcher
// Reports every occurrence of a loaded pattern in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, op, byte_value) carries one item per
//   op: append a pattern byte, finish the pattern (clears position and match
//   counters), a text byte, or a line break. Matches never span a line break,
//   but the break takes one text position. Overlapping matches are reported.
//   Output channel (out_valid / out_stall) returns one item per match: the
//   1-based position of the match's first byte and a running match number.
//   Both counters saturate at all ones.
// Timing:
//   One item per cycle while in_stall is low. Each text byte is compared
//   against all stored pattern bytes at once in the cell row, so a match is
//   known in the accept cycle and its item is in the output register next cycle.
//   in_stall is high only while a result is held and out_stall is high.
// Reset:
//   Pattern is empty, counters are zero and no pattern is finished, so text
//   produces no result until a finish item arrives.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] match_position,
    output logic [31:0] match_number
);

    localparam int N = kmp_pkg::PAT_LIMIT;
    localparam int W = kmp_pkg::LEN_W;

    kmp_pkg::cell_ctrl_t ctrl;
    kmp_pkg::op_t        op_code;

    logic [W-1:0]        len_reg;
    logic [W-1:0]        len_next;
    logic                ready_reg;
    logic                ready_next;
    logic [31:0]         pos_reg;
    logic [31:0]         pos_next;
    logic [31:0]         base_reg;
    logic [31:0]         base_next;
    logic [31:0]         total_reg;
    logic [31:0]         total_next;
    logic [31:0]         total_inc;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [31:0]         out_pos_reg;
    logic [31:0]         out_num_reg;
    logic                accept;
    logic                match_found;
    logic                head_hit;

    logic [7:0]          byte_chain  [N];
    logic                valid_chain [N];
    logic                prog_chain  [N];

    assign in_stall       = out_valid_reg & out_stall;
    assign accept         = in_valid & ~in_stall;
    assign op_code        = kmp_pkg::op_t'(op);
    assign out_valid      = out_valid_reg;
    assign match_position = out_pos_reg;
    assign match_number   = out_num_reg;

    assign total_inc = (total_reg == kmp_pkg::CNT_MAX) ? total_reg : total_reg + 32'd1;

    // Decode the accepted item into row control and counter updates
    always_comb
    begin
        ctrl         = '0;
        ctrl.data    = byte_value;
        len_next     = len_reg;
        ready_next   = ready_reg;
        pos_next     = pos_reg;
        base_next    = base_reg;
        if (accept)
        begin
            case (op_code)
                kmp_pkg::OP_APPEND:
                begin
                    ctrl.clear = 1'b1;
                    if (ready_reg)
                    begin
                        // Append after finish starts a new pattern
                        ctrl.load    = 1'b1;
                        ctrl.restart = 1'b1;
                        ready_next   = 1'b0;
                        len_next     = W'(1);
                    end
                    else if (len_reg < W'(N))
                    begin
                        ctrl.load = 1'b1;
                        len_next  = len_reg + W'(1);
                    end
                end
                kmp_pkg::OP_FINISH:
                begin
                    ctrl.clear = 1'b1;
                    ready_next = 1'b1;
                    pos_next   = '0;
                    base_next  = 32'd2 - 32'(len_reg);
                end
                kmp_pkg::OP_TEXT, kmp_pkg::OP_BREAK:
                begin
                    // Position advances with saturation; base tracks the start
                    // of a match ending at the next byte
                    if (pos_reg != kmp_pkg::CNT_MAX)
                    begin
                        pos_next = pos_reg + 32'd1;
                    end
                    if (pos_reg < kmp_pkg::CNT_MAX - 32'd1)
                    begin
                        base_next = base_reg + 32'd1;
                    end
                    if (op_code == kmp_pkg::OP_BREAK)
                    begin
                        ctrl.clear = 1'b1;
                    end
                    else
                    begin
                        ctrl.step = 1'b1;
                    end
                end
                default:
                begin
                    ctrl.clear = 1'b1;
                end
            endcase
        end
    end

    // Match report from the head cell; finish restarts the match count
    assign match_found = accept & (op_code == kmp_pkg::OP_TEXT) & ready_reg & head_hit;
    assign total_next  = (accept && op_code == kmp_pkg::OP_FINISH) ? '0
                       : (match_found ? total_inc : total_reg);

    // Output register: held while stalled, refilled on a match
    assign out_valid_next = match_found | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ready_reg     <= 1'b0;
            pos_reg       <= '0;
            base_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ready_reg     <= ready_next;
            pos_reg       <= pos_next;
            base_reg      <= base_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (match_found)
        begin
            out_pos_reg <= base_reg;
            out_num_reg <= total_next;
        end
    end

    // Cell row: pattern bytes enter at cell 0 and move up, so cell 0 always
    // holds the last pattern byte and reports a complete match
    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            logic [7:0] byte_in;
            logic       valid_in;
            logic       prog_in;
            logic       hit;

            if (k == 0)
            begin : g_head
                assign byte_in  = byte_value;
                assign valid_in = 1'b1;
                assign head_hit = hit;
            end
            else
            begin : g_body
                assign byte_in  = byte_chain[k-1];
                assign valid_in = valid_chain[k-1] & ~ctrl.restart;
            end

            if (k == N - 1)
            begin : g_top
                assign prog_in = 1'b1;
            end
            else
            begin : g_inner
                assign prog_in = prog_chain[k+1];
            end

            kmp_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .byte_in   (byte_in),
                .valid_in  (valid_in),
                .prog_in   (prog_in),
                .byte_out  (byte_chain[k]),
                .valid_out (valid_chain[k]),
                .prog_out  (prog_chain[k]),
                .hit       (hit)
            );
        end
    endgenerate

endmodule

/* hw/rtl/kmp_checker.sv */
// ----------------------------------------------------------------------------
// kmp_checker: port-level checks for the KMP pattern matcher
// Watches the top-level channels and flags illegal behavior over time.
// ----------------------------------------------------------------------------
module kmp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  op,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] match_position,
    input logic [31:0] match_number
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(match_position)
                                  && $stable(match_number))
        else $error("stalled result changed");

    // Input is held back only by a stalled pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // A new result follows an accepted text byte
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall
                                   && op == kmp_pkg::OP_TEXT))
        else $error("result without an accepted text byte");

    // Match numbers start at one
    a_number_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> match_number != 32'd0)
        else $error("match number is zero");

    // A taken result with no text byte accepted leaves the output empty
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !(in_valid && !in_stall
            && op == kmp_pkg::OP_TEXT) |=> !out_valid)
        else $error("result appeared without a text byte");

endmodule

bind kmp_pattern_matcher kmp_checker u_kmp_checker (.*);

/* test/kmp_pattern_matcher_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmp_pattern_matcher_test: self-checking bench for the KMP pattern matcher
// Sends pattern, finish, text and line-break items with random gaps while the
// output side stalls at random. A matcher model built from the failure-link
// method predicts every match, and each output item is checked in order.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher_test;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 8;
    localparam int NO_LINK      = -1;
    localparam int NOT_A_BYTE   = 256;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] number;
    } match_t;

    // DUT ports
    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [7:0]  byte_value;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] match_position;
    logic [31:0] match_number;

    // Matcher model state
    logic [7:0]  pat_bytes [0:kmp_pkg::STORE_DEPTH-1];
    int          fail_link [0:kmp_pkg::STORE_DEPTH];
    int          pat_len;
    int          progress;
    logic [31:0] text_pos;
    logic [31:0] match_cnt;
    bit          table_built;

    match_t      pending_matches [$];
    int          items_sent;
    int          error_count;
    int          cycle_count;
    int          send_gap_pct;
    int          stall_pct;

    kmp_pattern_matcher dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .byte_value     (byte_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .match_position (match_position),
        .match_number   (match_number)
    );

    always #5 clk = ~clk;

    // Pattern byte at k, or a value no text byte can equal
    function automatic int pat_byte(int k);
        if (k < 0 || k >= pat_len)
            return NOT_A_BYTE;
        return int'(pat_bytes[k]);
    endfunction

    function automatic int fail_of(int k);
        if (k < 0 || k > kmp_pkg::STORE_DEPTH)
            return NO_LINK;
        return fail_link[k];
    endfunction

    // Knuth's optimized failure links
    function automatic void build_failure_links();
        int i;
        int j;
        int ci;
        j = 0;
        fail_link[0] = NO_LINK;
        for (i = 1; i <= pat_len; i++)
        begin
            ci = pat_byte(i);
            if (ci == pat_byte(j))
                fail_link[i] = fail_of(j);
            else
                fail_link[i] = j;
            while (j >= 0 && ci != pat_byte(j))
                j = fail_of(j);
            j++;
        end
    endfunction

    // Advance the model by one accepted item; queue a match if one completes
    function automatic void track_matcher(kmp_pkg::op_t item_op, logic [7:0] item_byte);
        int j;
        match_t hit;
        case (item_op)
            kmp_pkg::OP_APPEND:
            begin
                if (table_built)
                begin
                    table_built = 1'b0;
                    pat_len = 0;
                end
                if (pat_len < kmp_pkg::PAT_LIMIT)
                begin
                    pat_bytes[pat_len] = item_byte;
                    pat_len++;
                end
            end
            kmp_pkg::OP_FINISH:
            begin
                build_failure_links();
                table_built = 1'b1;
                progress = 0;
                text_pos = '0;
                match_cnt = '0;
            end
            default:
            begin
                if (text_pos != kmp_pkg::CNT_MAX)
                    text_pos++;
                if (item_op == kmp_pkg::OP_BREAK)
                begin
                    progress = 0;
                end
                else if (table_built && pat_len != 0)
                begin
                    j = progress;
                    if (j < 0 || j >= pat_len)
                        j = 0;
                    while (j >= 0 && int'(item_byte) != pat_byte(j))
                        j = fail_of(j);
                    j++;
                    if (j < pat_len)
                    begin
                        progress = j;
                    end
                    else
                    begin
                        // resume at the border so overlaps are found
                        j = fail_of(pat_len);
                        if (j < 0 || j >= pat_len)
                            j = 0;
                        progress = j;
                        if (match_cnt != kmp_pkg::CNT_MAX)
                            match_cnt++;
                        hit.position = text_pos - 32'(pat_len) + 32'd1;
                        hit.number = match_cnt;
                        pending_matches.push_back(hit);
                    end
                end
            end
        endcase
    endfunction

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endfunction

    // Drive one item with random idle cycles ahead of it; returns at acceptance
    task automatic send_item(kmp_pkg::op_t item_op, logic [7:0] item_byte);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= item_op;
        byte_value <= item_byte;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_matcher(item_op, item_byte);
        items_sent++;
    endtask

    // Output side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each output item with the oldest predicted match
    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_matches.size() == 0)
            begin
                flag_error($sformatf("unexpected match: position %0d number %0d",
                                     match_position, match_number));
            end
            else
            begin
                want = pending_matches.pop_front();
                if (match_position !== want.position)
                    flag_error($sformatf("match_position: expected %0d, got %0d",
                                         want.position, match_position));
                if (match_number !== want.number)
                    flag_error($sformatf("match_number: expected %0d, got %0d",
                                         want.number, match_number));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** kmp_pattern_matcher: FAILED **");
            $finish;
        end
    end

    // Finish with nothing loaded: text never matches
    task automatic test_empty_pattern();
        send_item(kmp_pkg::OP_FINISH, 8'h00);
        send_item(kmp_pkg::OP_TEXT, 8'h00);
        send_item(kmp_pkg::OP_TEXT, 8'hFF);
        send_item(kmp_pkg::OP_BREAK, 8'hFF);
    endtask

    // Appending after a finish starts a new pattern; text before finish is silent
    task automatic test_text_before_finish();
        send_item(kmp_pkg::OP_APPEND, 8'h61);
        send_item(kmp_pkg::OP_APPEND, 8'h62);
        send_item(kmp_pkg::OP_TEXT, 8'h61);
        send_item(kmp_pkg::OP_TEXT, 8'h62);
    endtask

    // Overlapping matches, and a line break that cuts progress
    task automatic test_overlap_and_break();
        send_item(kmp_pkg::OP_FINISH, 8'h00);
        send_item(kmp_pkg::OP_APPEND, 8'h00);
        send_item(kmp_pkg::OP_APPEND, 8'h00);
        send_item(kmp_pkg::OP_FINISH, 8'hFF);
        send_item(kmp_pkg::OP_TEXT, 8'h00);
        send_item(kmp_pkg::OP_TEXT, 8'h00);
        send_item(kmp_pkg::OP_TEXT, 8'h00);
        send_item(kmp_pkg::OP_TEXT, 8'h00);
        send_item(kmp_pkg::OP_TEXT, 8'h00);
        send_item(kmp_pkg::OP_BREAK, 8'h00);
        send_item(kmp_pkg::OP_TEXT, 8'h00);
        send_item(kmp_pkg::OP_TEXT, 8'hFF);
    endtask

    // Second finish rebuilds the table and restarts both counters
    task automatic test_finish_twice();
        send_item(kmp_pkg::OP_FINISH, 8'h00);
        send_item(kmp_pkg::OP_TEXT, 8'h00);
        send_item(kmp_pkg::OP_TEXT, 8'h00);
    endtask

    // Single-byte pattern loaded over a finished one
    task automatic test_append_after_finish();
        send_item(kmp_pkg::OP_APPEND, 8'hFF);
        send_item(kmp_pkg::OP_TEXT, 8'hFF);
        send_item(kmp_pkg::OP_FINISH, 8'h00);
        send_item(kmp_pkg::OP_TEXT, 8'hFF);
        send_item(kmp_pkg::OP_TEXT, 8'hFF);
    endtask

    // Pattern bytes past the store limit are dropped
    task automatic test_pattern_overflow();
        send_item(kmp_pkg::OP_FINISH, 8'h00);
        repeat (kmp_pkg::PAT_LIMIT + 3)
            send_item(kmp_pkg::OP_APPEND, 8'h5A);
        send_item(kmp_pkg::OP_FINISH, 8'h00);
        repeat (kmp_pkg::PAT_LIMIT + 1)
            send_item(kmp_pkg::OP_TEXT, 8'h5A);
        send_item(kmp_pkg::OP_BREAK, 8'h5A);
        repeat (kmp_pkg::PAT_LIMIT)
            send_item(kmp_pkg::OP_TEXT, 8'h5A);
    endtask

    // Mostly short patterns over small alphabets with matching text, plus noise
    task automatic test_random_traffic();
        int start;
        int done;
        int plen;
        int tlen;
        int nsym;
        int r;
        logic [7:0] sym [0:2];
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            done = items_sent - start;
            // quiet stretch with no idling in the middle third
            if (done > RANDOM_ITEMS / 3 && done < 2 * RANDOM_ITEMS / 3)
            begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                send_gap_pct = 14;
                stall_pct = 14;
            end
            if ($urandom_range(99) < 85)
            begin
                nsym = $urandom_range(1, 3);
                foreach (sym[s])
                    sym[s] = 8'($urandom_range(255));
                plen = ($urandom_range(9) == 0) ? $urandom_range(7, 24)
                                                : $urandom_range(1, 5);
                repeat (plen)
                    send_item(kmp_pkg::OP_APPEND, sym[$urandom_range(nsym - 1)]);
                send_item(kmp_pkg::OP_FINISH, 8'($urandom_range(255)));
                if ($urandom_range(9) == 0)
                    send_item(kmp_pkg::OP_FINISH, 8'($urandom_range(255)));
                tlen = $urandom_range(20, 60);
                repeat (tlen)
                begin
                    r = $urandom_range(99);
                    if (r < 5)
                        send_item(kmp_pkg::OP_BREAK, 8'($urandom_range(255)));
                    else if (r < 8)
                        send_item(kmp_pkg::OP_TEXT, 8'($urandom_range(255)));
                    else
                        send_item(kmp_pkg::OP_TEXT, sym[$urandom_range(nsym - 1)]);
                end
            end
            else
            begin
                // noise: any op, any byte
                repeat ($urandom_range(3, 12))
                    send_item(kmp_pkg::op_t'($urandom_range(3)),
                              8'($urandom_range(255)));
            end
        end
        send_gap_pct = 14;
        stall_pct = 14;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = kmp_pkg::OP_APPEND;
        byte_value   = 8'h00;
        pat_len      = 0;
        progress     = 0;
        text_pos     = '0;
        match_cnt    = '0;
        table_built  = 1'b0;
        items_sent   = 0;
        error_count  = 0;
        cycle_count  = 0;
        send_gap_pct = 14;
        stall_pct    = 14;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_pattern();
        test_text_before_finish();
        test_overlap_and_break();
        test_finish_twice();
        test_append_after_finish();
        test_pattern_overflow();
        test_random_traffic();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** kmp_pattern_matcher: PASSED **");
        else
            $display("** kmp_pattern_matcher: FAILED **");
        $finish;
    end

endmodule
